### design/lqba_pkg.sv
`timescale 1ns / 1ps

package lqba_pkg;

  localparam int WORD_W = 32;
  localparam int CAP_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_DISP = 2'd2,
    REQ_ADD  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ,
    ST_DISP,
    ST_ADD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data_word;
    logic                     last_of_run;
  } res_t;

endpackage

### design/linear_queue_with_bulk_add.sv
`timescale 1ns / 1ps

// Linear (non-circular) queue of 32-bit signed words with bulk add.
// Input channel in_*: one request per transfer (enqueue, dequeue, display,
// add addend to every held word). Result channel out_*: status, data word and
// a last flag on the final result of each request. cfg_wr_en/cfg_wr_data set
// the capacity (saturates at DEPTH); write it only while the block is idle.
// Timing: results leave through one output register. Enqueue and every
// empty/full case answer straight from the request transfer. Dequeue goes
// through a registered RAM read. Display of n words sends one word per cycle
// while the output is not stalled. Add over n words: the single RAM read
// port and the adder walk the held words one per cycle, then the status goes
// out. in_stall stays high until the request's last result is handed to the
// output register.
// Reset empties the queue (pointers to zero) and sets capacity to 16; stored
// words are not cleared. A high out_stall holds the output register and the
// block simply waits; nothing is dropped.
module linear_queue_with_bulk_add #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic signed [lqba_pkg::WORD_W-1:0]  in_enqueue_value,
  input  logic signed [lqba_pkg::WORD_W-1:0]  in_addend,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic signed [lqba_pkg::WORD_W-1:0]  out_data_word,
  output logic                                out_last_of_run,
  input  logic                                cfg_wr_en,
  input  logic [lqba_pkg::CAP_W-1:0]          cfg_wr_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(DEPTH + 1);

  logic                        res_valid;
  logic                        res_ready;
  lqba_pkg::res_t              res;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [lqba_pkg::WORD_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [lqba_pkg::WORD_W-1:0] rd_data;

  logic           out_valid_r;
  lqba_pkg::res_t out_r;

  assign res_ready = !out_valid_r || !out_stall;

  lqba_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .PW   (PW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_enqueue_value(in_enqueue_value),
    .in_addend       (in_addend),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  lqba_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_data_word   = out_r.data_word;
  assign out_last_of_run = out_r.last_of_run;

endmodule

### design/lqba_mem.sv
`timescale 1ns / 1ps

module lqba_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [lqba_pkg::WORD_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [lqba_pkg::WORD_W-1:0]   rd_data
);

  logic [lqba_pkg::WORD_W-1:0] mem [0:DEPTH-1];
  logic [lqba_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/lqba_ctrl.sv
`timescale 1ns / 1ps

module lqba_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int PW    = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic signed [lqba_pkg::WORD_W-1:0]  in_enqueue_value,
  input  logic signed [lqba_pkg::WORD_W-1:0]  in_addend,
  input  logic                                cfg_wr_en,
  input  logic [lqba_pkg::CAP_W-1:0]          cfg_wr_data,
  output logic                                res_valid,
  input  logic                                res_ready,
  output lqba_pkg::res_t                      res,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic [lqba_pkg::WORD_W-1:0]         wr_data,
  output logic                                rd_en,
  output logic [AW-1:0]                       rd_addr,
  input  logic [lqba_pkg::WORD_W-1:0]         rd_data
);

  localparam int CMPW = (PW > lqba_pkg::CAP_W) ? PW : lqba_pkg::CAP_W;

  lqba_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [lqba_pkg::WORD_W-1:0] addend_r, addend_nxt;
  logic [lqba_pkg::CAP_W-1:0] cap_r;

  logic          in_xfer;
  logic          empty;
  logic          full;
  logic [PW-1:0] ptr_inc;
  logic [PW-1:0] head_inc;
  logic          ptr_last;
  logic          head_last;
  lqba_pkg::req_t req;

  assign req       = lqba_pkg::req_t'(in_req_type);
  assign in_stall  = !((state_r == lqba_pkg::ST_IDLE) && res_ready);
  assign in_xfer   = in_valid && !in_stall;
  assign empty     = head_r >= tail_r;
  // effective capacity is min(capacity, DEPTH)
  assign full      = (CMPW'(tail_r) >= CMPW'(cap_r)) || (tail_r >= PW'(DEPTH));
  assign ptr_inc   = ptr_r + PW'(1);
  assign head_inc  = head_r + PW'(1);
  assign ptr_last  = ptr_inc >= tail_r;
  assign head_last = head_inc >= tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lqba_pkg::ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cap_r   <= lqba_pkg::CAP_RESET;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    addend_r <= addend_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lqba_pkg::ST_IDLE: begin
        if (in_xfer && !empty) begin
          unique case (req)
            lqba_pkg::REQ_DEQ:  state_nxt = lqba_pkg::ST_DEQ;
            lqba_pkg::REQ_DISP: state_nxt = lqba_pkg::ST_DISP;
            lqba_pkg::REQ_ADD:  state_nxt = lqba_pkg::ST_ADD;
            default:            state_nxt = lqba_pkg::ST_IDLE;
          endcase
        end
      end
      lqba_pkg::ST_DEQ: begin
        if (res_ready) begin
          state_nxt = lqba_pkg::ST_IDLE;
        end
      end
      lqba_pkg::ST_DISP: begin
        if (res_ready && ptr_last) begin
          state_nxt = lqba_pkg::ST_IDLE;
        end
      end
      lqba_pkg::ST_ADD: begin
        if (ptr_last) begin
          state_nxt = lqba_pkg::ST_FIN;
        end
      end
      lqba_pkg::ST_FIN: begin
        if (res_ready) begin
          state_nxt = lqba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lqba_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    res_valid       = 1'b0;
    res.status      = lqba_pkg::STAT_OK;
    res.data_word   = '0;
    res.last_of_run = 1'b1;
    wr_en           = 1'b0;
    wr_addr         = tail_r[AW-1:0];
    wr_data         = in_enqueue_value;
    rd_en           = 1'b0;
    rd_addr         = head_r[AW-1:0];
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    ptr_nxt         = ptr_r;
    addend_nxt      = addend_r;
    unique case (state_r)
      lqba_pkg::ST_IDLE: begin
        ptr_nxt    = head_r;
        addend_nxt = in_addend;
        if (in_xfer) begin
          if (req == lqba_pkg::REQ_ENQ) begin
            res_valid = 1'b1;
            if (full) begin
              res.status = lqba_pkg::STAT_FULL;
            end else begin
              wr_en    = 1'b1;
              tail_nxt = tail_r + PW'(1);
            end
          end else if (empty) begin
            res_valid  = 1'b1;
            res.status = lqba_pkg::STAT_EMPTY;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      lqba_pkg::ST_DEQ: begin
        res_valid     = 1'b1;
        res.data_word = rd_data;
        if (res_ready) begin
          if (head_last) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            head_nxt = head_inc;
          end
        end
      end
      lqba_pkg::ST_DISP: begin
        res_valid       = 1'b1;
        res.data_word   = rd_data;
        res.last_of_run = ptr_last;
        if (res_ready && !ptr_last) begin
          ptr_nxt = ptr_inc;
          rd_en   = 1'b1;
          rd_addr = ptr_inc[AW-1:0];
        end
      end
      lqba_pkg::ST_ADD: begin
        // read-modify-write, one word per cycle
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        wr_data = rd_data + addend_r;
        if (!ptr_last) begin
          ptr_nxt = ptr_inc;
          rd_en   = 1'b1;
          rd_addr = ptr_inc[AW-1:0];
        end
      end
      lqba_pkg::ST_FIN: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

endmodule

### design/lqba_chk.sv
`timescale 1ns / 1ps

module lqba_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          out_status,
  input logic signed [lqba_pkg::WORD_W-1:0]  out_data_word,
  input logic                                out_last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_data_word) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= lqba_pkg::STAT_EMPTY)
    else $error("undefined status code");

  // full or empty always ends the request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lqba_pkg::STAT_OK) |-> out_last_of_run)
    else $error("error status without last flag");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lqba_pkg::STAT_OK) |-> out_data_word == '0)
    else $error("error status with nonzero data");

endmodule

bind linear_queue_with_bulk_add lqba_chk u_lqba_chk (.*);
